[sv/fvcu_pkg.sv]
// Shared constants, types and register codes for the finite-volume cell update block.
package fvcu_pkg;

    localparam int VAL_W      = 48;
    localparam int AREA_W     = 47;
    localparam int CFG_W      = 47;
    localparam int COMP_W     = 2;
    localparam int MASK_W     = 4;
    localparam int NUM_EDGES  = 4;
    localparam int NUM_COMP   = 4;
    localparam int RES_W      = VAL_W + 3;
    localparam int RMAG_W     = RES_W + 1;
    localparam int QUOT_W     = RMAG_W;
    localparam int MUL_STEPS  = VAL_W;
    localparam int PROD_W     = CFG_W + RMAG_W;
    localparam int FRAC_BITS  = 32;
    localparam int SUM_W      = 64;
    localparam int RAD_W      = SUM_W + FRAC_BITS;
    localparam int ROOT_W     = RAD_W / 2;
    localparam int ROOT_SUM_W = ROOT_W + 2;
    localparam int STEP_W     = $clog2(QUOT_W);

    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b1;

    localparam logic [CFG_W-1:0]  THRESH_RESET = CFG_W'(43);
    localparam logic [QUOT_W-1:0] MAG_CAP      = QUOT_W'(1) << 50;
    localparam logic [VAL_W-1:0]  VAL_MAX      = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0]  VAL_MIN      = {1'b1, {(VAL_W-1){1'b0}}};

    localparam int MAX_CELLS_DEF   = 65536;
    localparam int QUEUE_DEPTH_DEF = 2;

    typedef struct packed {
        logic [COMP_W-1:0] comp;
        logic [VAL_W-1:0]  old_value;
        logic              res_neg;
        logic [RMAG_W-1:0] res_mag;
        logic [AREA_W-1:0] area;
        logic              ghost;
        logic              eop;
    } t_work;

endpackage

[sv/fvcu_front.sv]
// Front end: accepts an item and forms the signed flux residue.
module fvcu_front import fvcu_pkg::*; (
    input  logic                push,
    output logic                full,
    input  logic                i_q_full,
    output logic                o_q_wr,
    input  logic [COMP_W-1:0]   i_component,
    input  logic [VAL_W-1:0]    i_old_value,
    input  logic [VAL_W-1:0]    i_flux_one,
    input  logic [VAL_W-1:0]    i_flux_two,
    input  logic [VAL_W-1:0]    i_flux_three,
    input  logic [VAL_W-1:0]    i_flux_four,
    input  logic [MASK_W-1:0]   i_owner_mask,
    input  logic [AREA_W-1:0]   i_cell_area,
    input  logic                i_is_ghost,
    input  logic                i_end_of_pass,
    output t_work               o_work
);

    logic [VAL_W-1:0]  flux [NUM_EDGES];
    logic [RES_W-1:0]  res;
    logic [RMAG_W-1:0] res_x;

    assign flux[0] = i_flux_one;
    assign flux[1] = i_flux_two;
    assign flux[2] = i_flux_three;
    assign flux[3] = i_flux_four;

    always_comb begin
        res = '0;
        for (int k = 0; k < NUM_EDGES; k++) begin
            if (i_owner_mask[k]) begin
                res = res + {{(RES_W-VAL_W){flux[k][VAL_W-1]}}, flux[k]};
            end else begin
                res = res - {{(RES_W-VAL_W){flux[k][VAL_W-1]}}, flux[k]};
            end
        end
    end

    assign res_x = {res[RES_W-1], res};

    assign full   = i_q_full;
    assign o_q_wr = push & ~i_q_full;

    always_comb begin
        o_work.comp      = i_component;
        o_work.old_value = i_old_value;
        o_work.res_neg   = res[RES_W-1];
        o_work.res_mag   = res[RES_W-1] ? (~res_x + RMAG_W'(1)) : res_x;
        o_work.area      = i_cell_area;
        o_work.ghost     = i_is_ghost;
        o_work.eop       = i_end_of_pass;
    end

endmodule

[sv/fvcu_fifo.sv]
// Short word queue between the front end and the back end.
module fvcu_fifo import fvcu_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr,
    input  t_work i_wdata,
    output logic  o_full,
    input  logic  i_rd,
    output t_work o_rdata,
    output logic  o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_work            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_wr) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (i_rd) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
            if (i_wr && !i_rd) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_rd && !i_wr) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

[sv/fvcu_back.sv]
// Back end: serial multiply/divide/root sequencer, norm sums and result register.
module fvcu_back import fvcu_pkg::*; #(
    parameter int MAX_CELLS = MAX_CELLS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    output logic              o_q_rd,
    input  t_work             i_q_data,
    input  logic [CFG_W-1:0]  i_time_step,
    input  logic [CFG_W-1:0]  i_threshold,
    output logic              empty,
    input  logic              pop,
    output logic [VAL_W-1:0]  o_new_value,
    output logic [VAL_W-1:0]  o_change_error,
    output logic              o_pass_done,
    output logic              o_converged,
    output logic [VAL_W-1:0]  o_norm_total
);

    localparam int CNT_W = $clog2(MAX_CELLS + 1);
    localparam int THR_W = CFG_W + CNT_W;
    localparam int CMP_W = (THR_W > ROOT_SUM_W) ? THR_W : ROOT_SUM_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MUL    = 4'd1;
    localparam logic [3:0] S_DIVPRE = 4'd2;
    localparam logic [3:0] S_DIV    = 4'd3;
    localparam logic [3:0] S_NEWV   = 4'd4;
    localparam logic [3:0] S_ERR    = 4'd5;
    localparam logic [3:0] S_SQ     = 4'd6;
    localparam logic [3:0] S_ACC    = 4'd7;
    localparam logic [3:0] S_EOP    = 4'd8;
    localparam logic [3:0] S_RLOAD  = 4'd9;
    localparam logic [3:0] S_ROOT   = 4'd10;
    localparam logic [3:0] S_THR    = 4'd11;
    localparam logic [3:0] S_FIN    = 4'd12;
    localparam logic [3:0] S_OUT    = 4'd13;

    logic [3:0]          r_state;
    t_work               r_w;
    logic [STEP_W-1:0]   r_step;

    logic [PROD_W-1:0]    r_ma;
    logic [MUL_STEPS-1:0] r_mb;
    logic [PROD_W-1:0]    r_acc;

    logic [AREA_W-1:0]   r_rem;
    logic [QUOT_W-1:0]   r_dvd;
    logic [QUOT_W-1:0]   r_quot;
    logic [QUOT_W-1:0]   r_mag;

    logic [VAL_W-1:0]    r_nv;
    logic [VAL_W-1:0]    r_err;

    logic [SUM_W-1:0]    r_sums [NUM_COMP];
    logic [CNT_W-1:0]    r_cnt;

    logic [RAD_W-1:0]      r_rad;
    logic [ROOT_W-1:0]     r_srem;
    logic [ROOT_W-1:0]     r_root;
    logic [ROOT_SUM_W-1:0] r_rsum;
    logic [1:0]            r_sidx;
    logic [THR_W-1:0]      r_thr_prod;

    logic                r_done;
    logic                r_conv;
    logic [VAL_W-1:0]    r_total;

    logic                r_out_valid;
    logic [VAL_W-1:0]    r_o_nv;
    logic [VAL_W-1:0]    r_o_err;
    logic                r_o_done;
    logic                r_o_conv;
    logic [VAL_W-1:0]    r_o_total;

    // divider step
    logic [AREA_W:0]     div_t;
    logic                div_ge;
    logic [AREA_W:0]     div_d;
    logic [QUOT_W-1:0]   n_quot;

    // update of value
    logic [VAL_W+3:0]    nv_sum;
    logic                nv_ovf;
    logic [VAL_W-1:0]    a_old;
    logic [VAL_W-1:0]    a_new;
    logic [VAL_W:0]      e_diff;
    logic [VAL_W-1:0]    n_err;
    logic [VAL_W-1:0]    e_mag;

    // root step
    logic [ROOT_W+1:0]   rt_t;
    logic [ROOT_W+1:0]   rt_trial;
    logic                rt_ge;
    logic [ROOT_W+1:0]   rt_d;
    logic [ROOT_W-1:0]   n_root;

    logic [SUM_W-1:0]    sq_val;
    logic [SUM_W:0]      sq_sum;
    logic                out_load;

    assign div_t  = {r_rem, r_dvd[QUOT_W-1]};
    assign div_ge = (div_t >= {1'b0, r_w.area});
    assign div_d  = div_t - {1'b0, r_w.area};
    assign n_quot = {r_quot[QUOT_W-2:0], div_ge};

    assign nv_sum = r_w.res_neg
                  ? ({{4{r_w.old_value[VAL_W-1]}}, r_w.old_value} + (VAL_W+4)'(r_mag))
                  : ({{4{r_w.old_value[VAL_W-1]}}, r_w.old_value} - (VAL_W+4)'(r_mag));
    assign nv_ovf = ~((&nv_sum[VAL_W+3:VAL_W-1]) | ~(|nv_sum[VAL_W+3:VAL_W-1]));

    assign a_old  = r_w.old_value[VAL_W-1] ? (~r_w.old_value + VAL_W'(1)) : r_w.old_value;
    assign a_new  = r_nv[VAL_W-1] ? (~r_nv + VAL_W'(1)) : r_nv;
    assign e_diff = {1'b0, a_new} - {1'b0, a_old};
    assign n_err  = (!e_diff[VAL_W] && e_diff[VAL_W-1]) ? VAL_MAX : e_diff[VAL_W-1:0];
    assign e_mag  = n_err[VAL_W-1] ? (~n_err + VAL_W'(1)) : n_err;

    assign rt_t     = {r_srem, r_rad[RAD_W-1:RAD_W-2]};
    assign rt_trial = {r_root, 2'b01};
    assign rt_ge    = (rt_t >= rt_trial);
    assign rt_d     = rt_t - rt_trial;
    assign n_root   = {r_root[ROOT_W-2:0], rt_ge};

    assign sq_val = r_acc[FRAC_BITS+SUM_W-1:FRAC_BITS];
    assign sq_sum = {1'b0, r_sums[r_w.comp]} + {1'b0, sq_val};

    assign o_q_rd   = (r_state == S_IDLE) && !i_q_empty;
    assign out_load = (r_state == S_OUT) && (!r_out_valid || pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            for (int j = 0; j < NUM_COMP; j++) begin
                r_sums[j] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_w    <= i_q_data;
                        r_nv   <= i_q_data.old_value;
                        r_err  <= '0;
                        r_ma   <= PROD_W'(i_q_data.res_mag);
                        r_mb   <= MUL_STEPS'(i_time_step);
                        r_acc  <= '0;
                        r_step <= '0;
                        r_state <= i_q_data.ghost ? S_EOP : S_MUL;
                    end
                end
                S_MUL, S_SQ: begin
                    if (r_mb[0]) begin
                        r_acc <= r_acc + r_ma;
                    end
                    r_ma   <= r_ma << 1;
                    r_mb   <= r_mb >> 1;
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(MUL_STEPS - 1)) begin
                        r_state <= (r_state == S_MUL) ? S_DIVPRE : S_ACC;
                    end
                end
                S_DIVPRE: begin
                    r_rem  <= r_acc[PROD_W-1:QUOT_W];
                    r_dvd  <= r_acc[QUOT_W-1:0];
                    r_quot <= '0;
                    r_step <= '0;
                    if (r_acc == '0) begin
                        r_mag   <= '0;
                        r_state <= S_NEWV;
                    end else if (r_acc[PROD_W-1:QUOT_W] >= r_w.area) begin
                        r_mag   <= MAG_CAP;
                        r_state <= S_NEWV;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem  <= div_ge ? div_d[AREA_W-1:0] : div_t[AREA_W-1:0];
                    r_dvd  <= r_dvd << 1;
                    r_quot <= n_quot;
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(QUOT_W - 1)) begin
                        r_mag   <= (n_quot > MAG_CAP) ? MAG_CAP : n_quot;
                        r_state <= S_NEWV;
                    end
                end
                S_NEWV: begin
                    r_nv <= nv_ovf ? (nv_sum[VAL_W+3] ? VAL_MIN : VAL_MAX)
                                   : nv_sum[VAL_W-1:0];
                    r_state <= S_ERR;
                end
                S_ERR: begin
                    r_err   <= n_err;
                    r_ma    <= PROD_W'(e_mag);
                    r_mb    <= e_mag;
                    r_acc   <= '0;
                    r_step  <= '0;
                    r_state <= S_SQ;
                end
                S_ACC: begin
                    r_sums[r_w.comp] <= sq_sum[SUM_W] ? '1 : sq_sum[SUM_W-1:0];
                    if (r_w.comp == '0 && r_cnt < CNT_W'(MAX_CELLS)) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                    r_state <= S_EOP;
                end
                S_EOP: begin
                    r_done  <= 1'b0;
                    r_conv  <= 1'b0;
                    r_total <= '0;
                    r_rsum  <= '0;
                    r_sidx  <= '0;
                    r_state <= r_w.eop ? S_RLOAD : S_OUT;
                end
                S_RLOAD: begin
                    r_rad   <= {r_sums[r_sidx], {FRAC_BITS{1'b0}}};
                    r_srem  <= '0;
                    r_root  <= '0;
                    r_step  <= '0;
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    r_srem <= rt_ge ? rt_d[ROOT_W-1:0] : rt_t[ROOT_W-1:0];
                    r_root <= n_root;
                    r_rad  <= r_rad << 2;
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(ROOT_W - 1)) begin
                        r_rsum <= r_rsum + ROOT_SUM_W'(n_root);
                        r_sidx <= r_sidx + 2'd1;
                        r_state <= (r_sidx == 2'(NUM_COMP - 1)) ? S_THR : S_RLOAD;
                    end
                end
                S_THR: begin
                    r_thr_prod <= THR_W'(i_threshold) * THR_W'(r_cnt);
                    r_state    <= S_FIN;
                end
                S_FIN: begin
                    r_total <= (r_rsum > ROOT_SUM_W'({VAL_W{1'b1}})) ? '1
                                                                     : r_rsum[VAL_W-1:0];
                    r_conv  <= (r_cnt != '0)
                            && (CMP_W'(r_rsum) <= CMP_W'(r_thr_prod));
                    r_done  <= 1'b1;
                    r_cnt   <= '0;
                    for (int j = 0; j < NUM_COMP; j++) begin
                        r_sums[j] <= '0;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_nv    <= r_nv;
            r_o_err   <= r_err;
            r_o_done  <= r_done;
            r_o_conv  <= r_conv;
            r_o_total <= r_total;
        end
    end

    assign empty          = ~r_out_valid;
    assign o_new_value    = r_o_nv;
    assign o_change_error = r_o_err;
    assign o_pass_done    = r_o_done;
    assign o_converged    = r_o_conv;
    assign o_norm_total   = r_o_total;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_CELLS))
        else $error("cell count above limit");

    a_pass_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> (r_cnt == '0 && r_sums[0] == '0 && r_sums[3] == '0))
        else $error("sums not cleared at end of pass");

    a_conv_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_conv) |-> r_o_done)
        else $error("converged without pass end");

    a_deq_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_rd |=> (r_state != S_IDLE))
        else $error("dequeued word not taken up");

endmodule

[sv/finite_volume_cell_update.sv]
// Top level of the finite-volume explicit Euler cell update block.
//
// Channel   Direction  Handshake            Payload
// input     in         push / full          component, old_value, flux_*, owner_mask,
//                                           cell_area, is_ghost, end_of_pass
// result    out        empty / pop          new_value, change_error, pass_done,
//                                           converged, norm_total
// config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// In the back end an ordinary cell word goes through a 48-step
// shift-add multiplier (residue times time step, then error squared) and a
// 52-step restoring divider by the area. A ghost word skips all of these.
// End of pass adds four 48-step square roots, one at a time.
// A two-word queue lets the front accept while the back works; the result
// register holds its word until popped and the back waits on it.
// Reset is synchronous, active low; config registers return to their defaults.
module finite_volume_cell_update import fvcu_pkg::*; #(
    parameter int MAX_CELLS   = MAX_CELLS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [COMP_W-1:0]     i_component,
    input  logic [VAL_W-1:0]      i_old_value,
    input  logic [VAL_W-1:0]      i_flux_one,
    input  logic [VAL_W-1:0]      i_flux_two,
    input  logic [VAL_W-1:0]      i_flux_three,
    input  logic [VAL_W-1:0]      i_flux_four,
    input  logic [MASK_W-1:0]     i_owner_mask,
    input  logic [AREA_W-1:0]     i_cell_area,
    input  logic                  i_is_ghost,
    input  logic                  i_end_of_pass,
    output logic                  empty,
    input  logic                  pop,
    output logic [VAL_W-1:0]      o_new_value,
    output logic [VAL_W-1:0]      o_change_error,
    output logic                  o_pass_done,
    output logic                  o_converged,
    output logic [VAL_W-1:0]      o_norm_total,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    logic [CFG_W-1:0] r_time_step;
    logic [CFG_W-1:0] r_threshold;

    logic  q_wr;
    logic  q_rd;
    logic  q_full;
    logic  q_empty;
    t_work q_wdata;
    t_work q_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= '0;
            r_threshold <= THRESH_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TIME_STEP: r_time_step <= i_cfg_data;
                CFG_THRESHOLD: r_threshold <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    fvcu_front u_front (
        .push          (push),
        .full          (full),
        .i_q_full      (q_full),
        .o_q_wr        (q_wr),
        .i_component   (i_component),
        .i_old_value   (i_old_value),
        .i_flux_one    (i_flux_one),
        .i_flux_two    (i_flux_two),
        .i_flux_three  (i_flux_three),
        .i_flux_four   (i_flux_four),
        .i_owner_mask  (i_owner_mask),
        .i_cell_area   (i_cell_area),
        .i_is_ghost    (i_is_ghost),
        .i_end_of_pass (i_end_of_pass),
        .o_work        (q_wdata)
    );

    fvcu_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    fvcu_back #(
        .MAX_CELLS (MAX_CELLS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .o_q_rd         (q_rd),
        .i_q_data       (q_rdata),
        .i_time_step    (r_time_step),
        .i_threshold    (r_threshold),
        .empty          (empty),
        .pop            (pop),
        .o_new_value    (o_new_value),
        .o_change_error (o_change_error),
        .o_pass_done    (o_pass_done),
        .o_converged    (o_converged),
        .o_norm_total   (o_norm_total)
    );

endmodule
